>>> sv/ftr_pkg.sv
// Package for the bitmap font text renderer.
// Holds item and result types, codes, font layout constants and the
// controller to datapath command and status structs. No dependencies.
package ftr_pkg;

  // sizes
  localparam int FONT_BYTES    = 4096;
  localparam int FONT_AW       = $clog2(FONT_BYTES);
  localparam int PANEL_MODULES = 4;
  localparam int PANEL_COLS    = PANEL_MODULES * 16;
  localparam int PANEL_WORDS   = PANEL_MODULES * 16;
  localparam int COL_W         = $clog2(PANEL_COLS);
  localparam int WORD_AW       = $clog2(PANEL_WORDS);

  // font header layout
  localparam logic [FONT_AW-1:0] HDR_HEIGHT = FONT_AW'(3);
  localparam logic [FONT_AW-1:0] HDR_FIRST  = FONT_AW'(4);
  localparam logic [FONT_AW-1:0] HDR_COUNT  = FONT_AW'(5);
  localparam logic [FONT_AW-1:0] WIDTH_BASE = FONT_AW'(6);

  // character codes
  localparam logic [6:0] CODE_BEL   = 7'd7;
  localparam logic [6:0] CODE_BS    = 7'd8;
  localparam logic [6:0] CODE_CR    = 7'd13;
  localparam logic [6:0] CODE_SPACE = 7'd32;

  localparam logic [8:0]  SPACE_ADV = 9'd4;
  localparam logic [14:0] PEN_MAX   = 15'h7fff;

  typedef enum logic [2:0] {
    FN_FONT_WR = 3'd0,
    FN_BEGIN   = 3'd1,
    FN_DRAW    = 3'd2,
    FN_CLEAR   = 3'd3,
    FN_READ    = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    COL_RED   = 2'd0,
    COL_GREEN = 2'd1,
    COL_AMBER = 2'd2
  } color_e;

  typedef enum logic [1:0] {
    CFG_START_X = 2'd0,
    CFG_START_Y = 2'd1,
    CFG_ROTATE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FA_HEIGHT = 3'd0,
    FA_FIRST  = 3'd1,
    FA_COUNT  = 3'd2,
    FA_SUM    = 3'd3,
    FA_WIDTH  = 3'd4,
    FA_PIXEL  = 3'd5
  } faddr_sel_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] font_addr;
    logic [7:0]  font_data;
    logic [6:0]  char_code;
    logic        read_plane;
    logic [5:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [8:0]  advance;
    logic [14:0] pen;
  } res_t;

  typedef struct packed {
    logic       item_load;
    logic       font_wr;
    logic       pen_clr;
    logic       plane_clr;
    logic       rd_issue;
    logic       set_color;
    logic       adv_zero;
    logic       adv_space;
    logic       cap_height;
    logic       cap_first;
    logic       cap_count;
    logic       sum_clr;
    logic       sum_acc;
    logic       glyph_start;
    logic       pix_rd;
    logic       pix_wr;
    logic       pix_step;
    logic       res_load;
    faddr_sel_e faddr_sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       is_color;
    logic       out_of_font;
    logic       is_space;
    logic       idx_zero;
    logic       sum_last;
    logic       glyph_empty;
    logic       pix_on;
    logic       pix_last;
    logic       out_free;
  } sts_t;

endpackage

>>> sv/ftr_ctrl.sv
// Controller state machine of the text renderer.
// Sequences header reads, width sum, pixel loop and result; uses ftr_pkg.
module ftr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ftr_pkg::sts_t sts_i,
  output ftr_pkg::cmd_t cmd_o
);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_DECODE = 15'h0002,
    ST_HDR3   = 15'h0004,
    ST_HDR4   = 15'h0008,
    ST_HDR5   = 15'h0010,
    ST_CNT    = 15'h0020,
    ST_CHK    = 15'h0040,
    ST_SUMR   = 15'h0080,
    ST_SUMA   = 15'h0100,
    ST_WID    = 15'h0200,
    ST_WIDC   = 15'h0400,
    ST_PXR    = 15'h0800,
    ST_PXT    = 15'h1000,
    ST_PXW    = 15'h2000,
    ST_DONE   = 15'h4000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    cmd_o     = '0;
    cmd_o.faddr_sel = ftr_pkg::FA_HEIGHT;
    state_d   = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.adv_zero = 1'b1;
        state_d = ST_DONE;
        case (sts_i.func)
          ftr_pkg::FN_FONT_WR: cmd_o.font_wr = 1'b1;
          ftr_pkg::FN_BEGIN:   cmd_o.pen_clr = 1'b1;
          ftr_pkg::FN_CLEAR:   cmd_o.plane_clr = 1'b1;
          ftr_pkg::FN_READ:    cmd_o.rd_issue = 1'b1;
          ftr_pkg::FN_DRAW: begin
            if (sts_i.is_color) cmd_o.set_color = 1'b1;
            else state_d = ST_HDR3;
          end
          default: ;
        endcase
      end
      ST_HDR3: begin
        cmd_o.faddr_sel = ftr_pkg::FA_HEIGHT;
        state_d = ST_HDR4;
      end
      ST_HDR4: begin
        cmd_o.faddr_sel  = ftr_pkg::FA_FIRST;
        cmd_o.cap_height = 1'b1;
        state_d = ST_HDR5;
      end
      ST_HDR5: begin
        cmd_o.faddr_sel = ftr_pkg::FA_COUNT;
        cmd_o.cap_first = 1'b1;
        state_d = ST_CNT;
      end
      ST_CNT: begin
        cmd_o.cap_count = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        cmd_o.sum_clr = 1'b1;
        if (sts_i.out_of_font) state_d = ST_DONE;
        else if (sts_i.is_space) begin
          cmd_o.adv_space = 1'b1;
          state_d = ST_DONE;
        end else if (sts_i.idx_zero) state_d = ST_WID;
        else state_d = ST_SUMR;
      end
      ST_SUMR: begin
        cmd_o.faddr_sel = ftr_pkg::FA_SUM;
        state_d = ST_SUMA;
      end
      ST_SUMA: begin
        cmd_o.sum_acc = 1'b1;
        state_d = sts_i.sum_last ? ST_WID : ST_SUMR;
      end
      ST_WID: begin
        cmd_o.faddr_sel = ftr_pkg::FA_WIDTH;
        state_d = ST_WIDC;
      end
      ST_WIDC: begin
        cmd_o.glyph_start = 1'b1;
        state_d = sts_i.glyph_empty ? ST_DONE : ST_PXR;
      end
      ST_PXR: begin
        cmd_o.faddr_sel = ftr_pkg::FA_PIXEL;
        state_d = ST_PXT;
      end
      ST_PXT: begin
        if (sts_i.pix_on) begin
          cmd_o.pix_rd = 1'b1;
          state_d = ST_PXW;
        end else begin
          cmd_o.pix_step = 1'b1;
          state_d = sts_i.pix_last ? ST_DONE : ST_PXR;
        end
      end
      ST_PXW: begin
        cmd_o.pix_wr   = 1'b1;
        cmd_o.pix_step = 1'b1;
        state_d = sts_i.pix_last ? ST_DONE : ST_PXR;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule

>>> sv/ftr_dp.sv
// Datapath of the text renderer: font memory, color planes, pen,
// configuration and result register. Uses ftr_pkg.
module ftr_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ftr_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ftr_pkg::res_t  out_item_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i,
  input  ftr_pkg::cmd_t  cmd_i,
  output ftr_pkg::sts_t  sts_o
);

  localparam int FAW = ftr_pkg::FONT_AW;
  localparam int WAW = ftr_pkg::WORD_AW;
  localparam int CW  = ftr_pkg::COL_W;

  ftr_pkg::item_t  item_q;
  ftr_pkg::color_e color_q;
  ftr_pkg::res_t   out_q;
  logic            out_valid_q;
  logic [15:0]     sx_q, sy_q;
  logic            rot_q;
  logic [7:0]      frd_q, height_q, first_q, count_q, width_q, x_q, y_q;
  logic [FAW-1:0]  base_q;
  logic [6:0]      k_q;
  logic [8:0]      adv_q;
  logic [14:0]     pen_q;
  logic [15:0]     red_rd_q, grn_rd_q;
  logic [WAW-1:0]  widx_q;
  logic [3:0]      wbit_q;

  logic [7:0]  font_mem [ftr_pkg::FONT_BYTES];
  logic [15:0] red_mem [ftr_pkg::PANEL_WORDS];
  logic [15:0] grn_mem [ftr_pkg::PANEL_WORDS];
  logic [ftr_pkg::PANEL_WORDS-1:0] red_vld_q, grn_vld_q;

  // glyph index and font checks
  logic [6:0] code_idx;
  logic [8:0] font_end;
  assign code_idx = item_q.char_code - first_q[6:0];
  assign font_end = {1'b0, first_q} + {1'b0, count_q};

  // pixel bit and panel position
  logic [4:0]    band;
  logic [12:0]   band_off;
  logic [3:0]    band_mul;
  logic [8:0]    sbit;
  logic          font_bit, in_panel;
  logic [17:0]   px;
  logic [16:0]   py;
  logic [CW-1:0] col;
  logic [3:0]    row;
  logic [WAW-1:0] pidx;
  logic          y_wrap;

  assign band     = y_q[7:3];
  assign band_off = band * width_q;
  assign band_mul = 4'd8 - {1'b0, height_q[2:0]};
  assign sbit     = ({4'd0, band} * {5'd0, band_mul}) + {6'd0, y_q[2:0]};
  assign font_bit = (sbit < 9'd8) && frd_q[sbit[2:0]];
  assign px = {{2{sx_q[15]}}, sx_q} + {3'b0, pen_q} + {10'b0, x_q};
  assign py = {sy_q[15], sy_q} + {9'b0, y_q};
  assign in_panel = !px[17] && (px[16:0] < 17'(ftr_pkg::PANEL_COLS)) &&
                    !py[16] && (py[15:0] < 16'd16);
  assign col  = rot_q ? (CW'(ftr_pkg::PANEL_COLS - 1) - px[CW-1:0]) : px[CW-1:0];
  assign row  = rot_q ? (4'd15 - py[3:0]) : py[3:0];
  assign pidx = WAW'((col & ~CW'(15)) | CW'(row));
  assign y_wrap = ({1'b0, y_q} + 9'd1 == {1'b0, height_q});

  // status to the controller
  always_comb begin
    sts_o.func        = item_q.func;
    sts_o.is_color    = (item_q.char_code == ftr_pkg::CODE_BEL) ||
                        (item_q.char_code == ftr_pkg::CODE_BS) ||
                        (item_q.char_code == ftr_pkg::CODE_CR);
    sts_o.out_of_font = ({1'b0, item_q.char_code} < first_q) ||
                        ({2'b0, item_q.char_code} >= font_end);
    sts_o.is_space    = (item_q.char_code == ftr_pkg::CODE_SPACE);
    sts_o.idx_zero    = (code_idx == 7'd0);
    sts_o.sum_last    = ({1'b0, k_q} + 8'd1 == {1'b0, code_idx});
    sts_o.glyph_empty = (frd_q == 8'd0) || (height_q == 8'd0);
    sts_o.pix_on      = font_bit && in_panel;
    sts_o.pix_last    = y_wrap && ({1'b0, x_q} + 9'd1 == {1'b0, width_q});
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  // font address select
  logic [FAW-1:0] faddr;
  always_comb begin
    case (cmd_i.faddr_sel)
      ftr_pkg::FA_HEIGHT: faddr = ftr_pkg::HDR_HEIGHT;
      ftr_pkg::FA_FIRST:  faddr = ftr_pkg::HDR_FIRST;
      ftr_pkg::FA_COUNT:  faddr = ftr_pkg::HDR_COUNT;
      ftr_pkg::FA_SUM:    faddr = ftr_pkg::WIDTH_BASE + FAW'(k_q);
      ftr_pkg::FA_WIDTH:  faddr = ftr_pkg::WIDTH_BASE + FAW'(code_idx);
      ftr_pkg::FA_PIXEL:  faddr = base_q + FAW'(x_q) + FAW'(band_off);
      default:            faddr = ftr_pkg::HDR_HEIGHT;
    endcase
  end

  // font memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.font_wr) font_mem[FAW'(item_q.font_addr)] <= item_q.font_data;
    frd_q <= font_mem[faddr];
  end

  // plane memories
  logic            rd_en;
  logic [WAW-1:0]  ridx;
  logic [15:0]     wmask;
  logic            wr_red, wr_grn;
  assign rd_en  = cmd_i.rd_issue || cmd_i.pix_rd;
  assign ridx   = cmd_i.rd_issue ? WAW'(item_q.read_index) : pidx;
  assign wmask  = 16'd1 << wbit_q;
  assign wr_red = cmd_i.pix_wr && (color_q != ftr_pkg::COL_GREEN);
  assign wr_grn = cmd_i.pix_wr && (color_q != ftr_pkg::COL_RED);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      red_rd_q <= red_vld_q[ridx] ? red_mem[ridx] : 16'd0;
      grn_rd_q <= grn_vld_q[ridx] ? grn_mem[ridx] : 16'd0;
    end
    if (cmd_i.pix_rd) begin
      widx_q <= pidx;
      wbit_q <= col[3:0];
    end
    if (wr_red) red_mem[widx_q] <= red_rd_q | wmask;
    if (wr_grn) grn_mem[widx_q] <= grn_rd_q | wmask;
  end

  // plane valid bits, cleared by reset and by clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_vld_q <= '0;
      grn_vld_q <= '0;
    end else if (cmd_i.plane_clr) begin
      red_vld_q <= '0;
      grn_vld_q <= '0;
    end else begin
      if (wr_red) red_vld_q[widx_q] <= 1'b1;
      if (wr_grn) grn_vld_q[widx_q] <= 1'b1;
    end
  end

  // glyph walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) item_q <= in_item_i;
    if (cmd_i.cap_height) height_q <= frd_q;
    if (cmd_i.cap_first) first_q <= frd_q;
    if (cmd_i.cap_count) count_q <= frd_q;
    if (cmd_i.sum_clr) begin
      base_q <= '0;
      k_q    <= '0;
    end else if (cmd_i.sum_acc) begin
      base_q <= base_q + ((height_q > 8'd8) ? FAW'({frd_q, 1'b0}) : FAW'(frd_q));
      k_q    <= k_q + 7'd1;
    end else if (cmd_i.glyph_start) begin
      base_q <= base_q + ftr_pkg::WIDTH_BASE + FAW'(count_q);
    end
    if (cmd_i.glyph_start) begin
      width_q <= frd_q;
      x_q     <= '0;
      y_q     <= '0;
    end else if (cmd_i.pix_step) begin
      if (y_wrap) begin
        y_q <= '0;
        x_q <= x_q + 8'd1;
      end else begin
        y_q <= y_q + 8'd1;
      end
    end
    if (cmd_i.adv_zero) adv_q <= '0;
    else if (cmd_i.adv_space) adv_q <= ftr_pkg::SPACE_ADV;
    else if (cmd_i.glyph_start) adv_q <= {1'b0, frd_q} + 9'd1;
  end

  // pen with saturation, and result
  logic [15:0] pen_sum;
  logic [14:0] pen_next;
  logic [15:0] rdata;
  assign pen_sum  = {1'b0, pen_q} + {7'd0, adv_q};
  assign pen_next = pen_sum[15] ? ftr_pkg::PEN_MAX : pen_sum[14:0];
  always_comb begin
    rdata = 16'd0;
    if ((item_q.func == ftr_pkg::FN_READ) &&
        (int'(item_q.read_index) < ftr_pkg::PANEL_WORDS))
      rdata = item_q.read_plane ? grn_rd_q : red_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q.read_data <= rdata;
      out_q.advance   <= adv_q;
      out_q.pen       <= pen_next;
    end
  end

  // control state: pen, color, config, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q       <= '0;
      color_q     <= ftr_pkg::COL_RED;
      sx_q        <= 16'd0;
      sy_q        <= 16'd1;
      rot_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.pen_clr) pen_q <= '0;
      else if (cmd_i.res_load) pen_q <= pen_next;
      if (cmd_i.set_color) begin
        case (item_q.char_code)
          ftr_pkg::CODE_BS:  color_q <= ftr_pkg::COL_GREEN;
          ftr_pkg::CODE_CR:  color_q <= ftr_pkg::COL_RED;
          ftr_pkg::CODE_BEL: color_q <= ftr_pkg::COL_AMBER;
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          ftr_pkg::CFG_START_X: sx_q  <= cfg_data_i;
          ftr_pkg::CFG_START_Y: sy_q  <= cfg_data_i;
          ftr_pkg::CFG_ROTATE:  rot_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.res_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> sv/font_text_renderer_led_matrix.sv
// Text renderer top: one item at a time; the next item is taken the cycle after a result loads.
// Font write, begin, clear, read, spare funcs and color codes go from decode to the result.
// A glyph reads header, width sum and its width, then each pixel (width*height), all through the
// shared font read port, writing lit panel pixels; out of font or space ends after the header.
// A result waiting in the output register holds the controller and stalls the input.
// Reset (async, active low) clears planes, pen, color red, start_y 1.
module font_text_renderer_led_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ftr_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ftr_pkg::res_t  out_item_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [15:0]    cfg_data_i
);

  ftr_pkg::cmd_t cmd;
  ftr_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ftr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ftr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
